// ----- hw/rtl/fdr_pkg.sv -----
// ----------------------------------------------------------------------------
// fdr_pkg: shared types, constants and step functions
// Holds the pipeline item type, the stage map and the arithmetic of one
// step of the reciprocal divider, the square root and the rounding squares.
// ----------------------------------------------------------------------------
package fdr_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE = 17'(1 << FRAC_BITS);
  localparam logic [19:0] ETA_MAX = 20'hFFFFF;

  // Stage map of the main pipeline.
  localparam int ST_RCP0     = 1;
  localparam int ST_RCP_LAST = 20;
  localparam int ST_SEL      = 21;
  localparam int ST_MUL1     = 22;
  localparam int ST_MUL2     = 23;
  localparam int ST_SQ_IN    = 24;
  localparam int ST_SQ0      = 25;
  localparam int ST_SQ_LAST  = 41;
  localparam int ST_AMP      = 42;
  localparam int ST_PIPE_END = 60;
  localparam int ST_SUM      = 61;
  localparam int ST_OUT      = 62;
  localparam int DIV_STEPS   = 17;

  typedef struct packed {
    logic        neg;
    logic [16:0] ci;
    logic [19:0] eta;
    logic [32:0] nd;
    logic        sat;
    logic [20:0] rem;
    logic [19:0] q;
    logic [16:0] s2i;
    logic [19:0] eta_it;
    logic [19:0] eta_ti;
    logic [24:0] s2t;
    logic [33:0] sv;
    logic [20:0] srem;
    logic [16:0] root;
  } fdr_item_t;

  // One restoring step of the reciprocal division: returns {rem, bit}.
  function automatic logic [21:0] rcp_step(input logic [20:0] rem, input logic nbit,
                                           input logic [19:0] eta);
    logic [20:0] r2;
    r2 = {rem[19:0], nbit};
    if (r2 >= {1'b0, eta}) begin
      return {r2 - {1'b0, eta}, 1'b1};
    end
    return {r2, 1'b0};
  endfunction

  // Rounded square of a cosine, in Q.16.
  function automatic logic [16:0] sq_round(input logic [16:0] ci);
    logic [34:0] p;
    p = 35'(ci) * 35'(ci) + 35'(ONE >> 1);
    return p[32:16];
  endfunction

  // One digit of the square root: returns {srem, root}.
  function automatic logic [37:0] sqrt_step(input logic [20:0] srem,
                                            input logic [16:0] root,
                                            input logic [1:0] pair);
    logic [20:0] r2;
    logic [20:0] trial;
    r2 = {srem[18:0], pair};
    trial = {2'b00, root, 2'b01};
    if (r2 >= trial) begin
      return {r2 - trial, root[15:0], 1'b1};
    end
    return {r2, root[15:0], 1'b0};
  endfunction

endpackage

// ----- hw/rtl/fdr_if.sv -----
// ----------------------------------------------------------------------------
// fdr_if: request channels of the Fresnel reflectance block
// Incoming angle/index requests and outgoing reflectance requests.
// ----------------------------------------------------------------------------
interface fdr_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] cos_incident;
  logic        [19:0] rel_index;
  modport source(output valid, cos_incident, rel_index, input ready);
  modport sink(input valid, cos_incident, rel_index, output ready);
endinterface

interface fdr_out_if;
  logic               valid;
  logic               ready;
  logic        [16:0] reflectance;
  logic signed [17:0] cos_transmitted;
  logic        [19:0] ratio_incident_to_trans;
  logic        [19:0] ratio_trans_to_incident;
  modport source(output valid, reflectance, cos_transmitted, ratio_incident_to_trans,
                 ratio_trans_to_incident, input ready);
  modport sink(input valid, reflectance, cos_transmitted, ratio_incident_to_trans,
               ratio_trans_to_incident, output ready);
endinterface

// ----- hw/rtl/fdr_amp_div.sv -----
// ----------------------------------------------------------------------------
// fdr_amp_div: pipelined amplitude ratio divider
// Forms round(|n - m| * ONE / (n + m)) one quotient bit per stage; ONE when n + m is zero.
// ----------------------------------------------------------------------------
module fdr_amp_div (
  input  logic        clk,
  input  logic        en,
  input  logic [36:0] n,
  input  logic [36:0] m,
  output logic [16:0] q
);

  logic [37:0] den_r  [0:fdr_pkg::DIV_STEPS];
  logic [37:0] rem_r  [0:fdr_pkg::DIV_STEPS];
  logic [16:0] dlo_r  [0:fdr_pkg::DIV_STEPS];
  logic [16:0] q_r    [0:fdr_pkg::DIV_STEPS];
  logic        zero_r [0:fdr_pkg::DIV_STEPS];

  logic [36:0] num;
  logic [37:0] den;
  logic [53:0] dvd;

  // Dividend num * ONE + den / 2; its upper part is always below den, so the
  // 17 restoring steps give the whole rounded quotient.
  assign num = (n >= m) ? n - m : m - n;
  assign den = {1'b0, n} + {1'b0, m};
  assign dvd = 54'({num, 16'd0}) + 54'(den >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= den;
      rem_r[0]  <= {1'b0, dvd[53:17]};
      dlo_r[0]  <= dvd[16:0];
      q_r[0]    <= '0;
      zero_r[0] <= (den == '0);
      for (int j = 1; j <= fdr_pkg::DIV_STEPS; j++) begin
        logic [38:0] r2;
        r2 = {rem_r[j-1], dlo_r[j-1][fdr_pkg::DIV_STEPS - j]};
        den_r[j]  <= den_r[j-1];
        dlo_r[j]  <= dlo_r[j-1];
        zero_r[j] <= zero_r[j-1];
        if (r2 >= {1'b0, den_r[j-1]}) begin
          rem_r[j] <= 38'(r2 - {1'b0, den_r[j-1]});
          q_r[j]   <= {q_r[j-1][15:0], 1'b1};
        end else begin
          rem_r[j] <= r2[37:0];
          q_r[j]   <= {q_r[j-1][15:0], 1'b0};
        end
      end
    end
  end

  assign q = zero_r[fdr_pkg::DIV_STEPS] ? fdr_pkg::ONE : q_r[fdr_pkg::DIV_STEPS];

endmodule

// ----- hw/rtl/fresnel_dielectric_reflectance.sv -----
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance: unpolarized Fresnel reflectance pipeline
// Fixed-point dielectric reflectance with transmitted cosine and index ratios.
// ----------------------------------------------------------------------------
// Usage: a source offers one request on in_req (signed Q1.16 incident cosine
// and unsigned Q4.16 relative index). The block answers each request with
// exactly one request on out_req carrying the reflectance, the signed
// transmitted cosine and the two index ratios, in acceptance order.
// Throughput: one request per cycle, sustained while out_req is not stalled.
// The pipeline is built around the bit-serial stages: 20 stages of the index
// reciprocal, 17 of the transmitted-cosine square root and 18 of the two
// parallel amplitude ratio dividers, plus multiply, select and output stages.
// Reset (rst_n low, synchronous) empties the pipeline: all valid bits clear
// and out_req.valid drops; no clearing pass is needed.
// Stalls: when out_req.ready is low with a result waiting, the entire
// pipeline freezes and in_req.ready falls, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance (
  input  logic            clk,
  input  logic            rst_n,
  fdr_in_if.sink          in_req,
  fdr_out_if.source       out_req
);

  // Every stage moves together; a stage holds whenever the output is blocked.
  logic adv;
  logic [fdr_pkg::ST_OUT:0] valid_r;

  fdr_pkg::fdr_item_t st_r   [0:fdr_pkg::ST_PIPE_END];
  fdr_pkg::fdr_item_t st_nxt [0:fdr_pkg::ST_PIPE_END];

  // Registered operands of the two amplitude dividers, and their quotients.
  logic [36:0] ns_r, ms_r, np_r, mp_r;
  logic [16:0] qs, qp;

  logic [34:0] sum_r;
  logic        sum_match_r, sum_graze_r, sum_neg_r;
  logic [16:0] sum_ct_r;
  logic [19:0] sum_it_r, sum_ti_r;

  logic [16:0]        refl_r;
  logic signed [17:0] cost_r;
  logic [19:0]        rit_r, rti_r;

  logic [17:0] mag;

  assign adv          = !valid_r[fdr_pkg::ST_OUT] || out_req.ready;
  assign in_req.ready = adv;

  assign mag = in_req.cos_incident[17] ? 18'(-in_req.cos_incident)
                                       : 18'(in_req.cos_incident);

  always_comb begin
    st_nxt[0]     = '0;
    st_nxt[0].neg = in_req.cos_incident[17];
    st_nxt[0].ci  = (mag > {1'b0, fdr_pkg::ONE}) ? fdr_pkg::ONE : mag[16:0];
    st_nxt[0].eta = in_req.rel_index;
    // Dividend of the rounded reciprocal: ONE*ONE + eta/2.
    st_nxt[0].nd  = {1'b1, 32'd0} + 33'(in_req.rel_index >> 1);
    st_nxt[0].rem = {8'd0, st_nxt[0].nd[32:20]};

    for (int k = 1; k <= fdr_pkg::ST_PIPE_END; k++) begin
      logic [21:0] rs;
      logic [37:0] ss;
      logic [36:0] p1;
      logic [40:0] p2;
      logic [16:0] s2c;
      logic [19:0] rcp;
      rs  = '0;
      ss  = '0;
      p1  = '0;
      p2  = '0;
      s2c = '0;
      rcp = '0;
      st_nxt[k] = st_r[k-1];
      if (k >= fdr_pkg::ST_RCP0 && k <= fdr_pkg::ST_RCP_LAST) begin
        rs = fdr_pkg::rcp_step(st_r[k-1].rem, st_r[k-1].nd[fdr_pkg::ST_RCP_LAST - k],
                               st_r[k-1].eta);
        st_nxt[k].rem = rs[21:1];
        st_nxt[k].q   = {st_r[k-1].q[18:0], rs[0]};
      end
      if (k == fdr_pkg::ST_RCP0) begin
        // The quotient overflows 20 bits exactly when the dividend reaches eta << 20.
        st_nxt[k].sat = ({7'd0, st_r[k-1].nd} >= {st_r[k-1].eta, 20'd0});
        st_nxt[k].s2i = fdr_pkg::ONE - fdr_pkg::sq_round(st_r[k-1].ci);
      end
      if (k == fdr_pkg::ST_SEL) begin
        rcp = st_r[k-1].sat ? fdr_pkg::ETA_MAX : st_r[k-1].q;
        st_nxt[k].eta_it = st_r[k-1].neg ? rcp : st_r[k-1].eta;
        st_nxt[k].eta_ti = st_r[k-1].neg ? st_r[k-1].eta : rcp;
      end
      if (k == fdr_pkg::ST_MUL1) begin
        p1 = 37'(st_r[k-1].eta_ti) * 37'(st_r[k-1].s2i);
        st_nxt[k].s2t = {4'd0, p1[36:16]};
      end
      if (k == fdr_pkg::ST_MUL2) begin
        p2 = 41'(st_r[k-1].s2t[20:0]) * 41'(st_r[k-1].eta_ti) + 41'(fdr_pkg::ONE >> 1);
        st_nxt[k].s2t = p2[40:16];
      end
      if (k == fdr_pkg::ST_SQ_IN) begin
        // Total internal reflection leaves a zero radicand and a zero cosine.
        s2c = fdr_pkg::ONE - st_r[k-1].s2t[16:0];
        st_nxt[k].sv   = (st_r[k-1].s2t >= 25'(fdr_pkg::ONE)) ? '0
                                                               : {1'b0, s2c, 16'd0};
        st_nxt[k].srem = '0;
        st_nxt[k].root = '0;
      end
      if (k >= fdr_pkg::ST_SQ0 && k <= fdr_pkg::ST_SQ_LAST) begin
        ss = fdr_pkg::sqrt_step(st_r[k-1].srem, st_r[k-1].root,
                                st_r[k-1].sv[2*(fdr_pkg::ST_SQ_LAST - k) +: 2]);
        st_nxt[k].srem = ss[37:17];
        st_nxt[k].root = ss[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[fdr_pkg::ST_OUT-1:0], in_req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= fdr_pkg::ST_PIPE_END; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Amplitude ratio operands: s uses (ci, etaIT*ct), p uses (ct, etaIT*ci).
  always_ff @(posedge clk) begin
    if (adv) begin
      ns_r <= {4'd0, st_r[fdr_pkg::ST_SQ_LAST].ci, 16'd0};
      ms_r <= 37'(st_r[fdr_pkg::ST_SQ_LAST].eta_it) * 37'(st_r[fdr_pkg::ST_SQ_LAST].root);
      np_r <= {4'd0, st_r[fdr_pkg::ST_SQ_LAST].root, 16'd0};
      mp_r <= 37'(st_r[fdr_pkg::ST_SQ_LAST].eta_it) * 37'(st_r[fdr_pkg::ST_SQ_LAST].ci);
    end
  end

  fdr_amp_div u_div_s (.clk(clk), .en(adv), .n(ns_r), .m(ms_r), .q(qs));
  fdr_amp_div u_div_p (.clk(clk), .en(adv), .n(np_r), .m(mp_r), .q(qp));

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r       <= 35'(qs) * 35'(qs) + 35'(qp) * 35'(qp);
      sum_match_r <= (st_r[fdr_pkg::ST_PIPE_END].eta == 20'(fdr_pkg::ONE));
      sum_graze_r <= (st_r[fdr_pkg::ST_PIPE_END].ci == '0);
      sum_neg_r   <= st_r[fdr_pkg::ST_PIPE_END].neg;
      sum_ct_r    <= st_r[fdr_pkg::ST_PIPE_END].root;
      sum_it_r    <= st_r[fdr_pkg::ST_PIPE_END].eta_it;
      sum_ti_r    <= st_r[fdr_pkg::ST_PIPE_END].eta_ti;
    end
  end

  // Output stage: mean of the squared ratios, then the matched and grazing cases and a clamp at one.
  logic [35:0] rsum;
  logic [18:0] rmean;
  assign rsum  = {1'b0, sum_r} + 36'(fdr_pkg::ONE);
  assign rmean = rsum[35:17];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sum_match_r) begin
        refl_r <= '0;
      end else if (sum_graze_r || rmean > 19'(fdr_pkg::ONE)) begin
        refl_r <= fdr_pkg::ONE;
      end else begin
        refl_r <= rmean[16:0];
      end
      cost_r <= sum_neg_r ? $signed({1'b0, sum_ct_r}) : -$signed({1'b0, sum_ct_r});
      rit_r  <= sum_it_r;
      rti_r  <= sum_ti_r;
    end
  end

  assign out_req.valid                   = valid_r[fdr_pkg::ST_OUT];
  assign out_req.reflectance             = refl_r;
  assign out_req.cos_transmitted         = cost_r;
  assign out_req.ratio_incident_to_trans = rit_r;
  assign out_req.ratio_trans_to_incident = rti_r;

`ifndef NO_ASSERTIONS
  a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_req.valid |-> out_req.reflectance <= fdr_pkg::ONE)
    else $error("reflectance above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_req.valid && !out_req.ready |=> out_req.valid && $stable(out_req.reflectance)
      && $stable(out_req.cos_transmitted))
    else $error("stalled result changed");

  a_ratio_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_req.valid && out_req.ratio_incident_to_trans == 20'(fdr_pkg::ONE)
      |-> out_req.ratio_trans_to_incident == 20'(fdr_pkg::ONE) && out_req.reflectance == '0)
    else $error("matched index gave nonzero reflectance");
`endif

endmodule
